// ===== hw/rtl/bfr_pkg.sv =====
// shared types and constants of the bus frame receiver
package bfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int DEV_W      = 2;
   localparam int UNIT_W     = 2;
   localparam int INDEX_W    = 6;
   localparam int ACCEPT_W   = 16;
   localparam int COMPLETE_W = 16;
   localparam int OVERSIZE_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DEV_CLASS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_NUMBER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_VALUE  = 2'd2;

   localparam logic [DEV_W-1:0]  DEV_CLASS_RST   = 2'd1;
   localparam logic [UNIT_W-1:0] UNIT_NUMBER_RST = 2'd1;
   localparam logic [BYTE_W-1:0] SYNC_VALUE_RST  = 8'h55;

   localparam logic [UNIT_W-1:0] UNIT_BROADCAST = 2'd0;

   localparam logic EVENT_DATA     = 1'b0;
   localparam logic EVENT_OVERSIZE = 1'b1;

   typedef struct packed {
      logic [DEV_W-1:0]  dev_class;
      logic [UNIT_W-1:0] unit_number;
      logic [BYTE_W-1:0] sync_value;
   } cfg_type;

   typedef struct packed {
      logic                  event_kind;
      logic [BYTE_W-1:0]     frame_command;
      logic [BYTE_W-1:0]     data_byte;
      logic [INDEX_W-1:0]    byte_index;
      logic                  last;
      logic                  broadcast;
      logic [ACCEPT_W-1:0]   frames_accepted;
      logic [COMPLETE_W-1:0] frames_completed;
      logic [OVERSIZE_W-1:0] oversize_errors;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/bfr_req_if.sv =====
// request channel carrying received bus bytes
interface bfr_req_if;
   logic                        valid;
   logic                        ready;
   logic [bfr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/bfr_rsp_if.sv =====
// result channel carrying frame events
interface bfr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            event_kind;
   logic [bfr_pkg::BYTE_W-1:0]      frame_command;
   logic [bfr_pkg::BYTE_W-1:0]      data_byte;
   logic [bfr_pkg::INDEX_W-1:0]     byte_index;
   logic                            last;
   logic                            broadcast;
   logic [bfr_pkg::ACCEPT_W-1:0]    frames_accepted;
   logic [bfr_pkg::COMPLETE_W-1:0]  frames_completed;
   logic [bfr_pkg::OVERSIZE_W-1:0]  oversize_errors;

   modport source (output valid, output event_kind, output frame_command, output data_byte,
                   output byte_index, output last, output broadcast, output frames_accepted,
                   output frames_completed, output oversize_errors, input ready);
   modport sink (input valid, input event_kind, input frame_command, input data_byte,
                 input byte_index, input last, input broadcast, input frames_accepted,
                 input frames_completed, input oversize_errors, output ready);
endinterface

// ===== hw/rtl/bus_frame_receiver.sv =====
// top level of the bus frame receiver
// Takes one received bus byte per cycle on req and delivers at most one event per byte on rsp.
// A request goes into an input register, is parsed once the parser may step and its event, if
// any, lands in an output register; a new request can be taken every cycle while the result
// side keeps up; a stalled output holds the parser and then the input register. Data bytes
// come out with their index and the final one is flagged; an empty frame gives one flagged
// event and an oversize length gives a drop event. Configuration registers are written through
// csr_ and should only change while no bytes are in flight.
module bus_frame_receiver #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   bfr_req_if.sink                          req,
   bfr_rsp_if.source                        rsp,
   input  logic                             csr_write_en,
   input  logic [bfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bfr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bfr_pkg::cfg_type              cfg;
   logic                          in_vld_ff;
   logic [bfr_pkg::BYTE_W-1:0]    in_byte_ff;
   logic                          out_vld_ff, out_vld_in;
   bfr_pkg::rsp_payload_type      out_ff;
   logic                          advance;
   logic                          rslt_vld;
   bfr_pkg::rsp_payload_type      rslt;

   bfr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   bfr_parser #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (advance),
      .rx_byte  (in_byte_ff),
      .rslt_vld (rslt_vld),
      .rslt     (rslt)
   );

   assign advance   = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || advance;

   always_comb begin
      out_vld_in = out_vld_ff && !rsp.ready;
      if (advance) begin
         out_vld_in = rslt_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_vld_ff <= req.valid;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
      end
      if (advance && rslt_vld) begin
         out_ff <= rslt;
      end
   end

   assign rsp.valid            = out_vld_ff;
   assign rsp.event_kind       = out_ff.event_kind;
   assign rsp.frame_command    = out_ff.frame_command;
   assign rsp.data_byte        = out_ff.data_byte;
   assign rsp.byte_index       = out_ff.byte_index;
   assign rsp.last             = out_ff.last;
   assign rsp.broadcast        = out_ff.broadcast;
   assign rsp.frames_accepted  = out_ff.frames_accepted;
   assign rsp.frames_completed = out_ff.frames_completed;
   assign rsp.oversize_errors  = out_ff.oversize_errors;

endmodule

// ===== hw/rtl/bfr_csr.sv =====
// configuration registers of the bus frame receiver
module bfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [bfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bfr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output bfr_pkg::cfg_type                 cfg
);

   bfr_pkg::cfg_type cfg_ff;
   bfr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            bfr_pkg::CSR_DEV_CLASS:   cfg_in.dev_class   = csr_wdata[bfr_pkg::DEV_W-1:0];
            bfr_pkg::CSR_UNIT_NUMBER: cfg_in.unit_number = csr_wdata[bfr_pkg::UNIT_W-1:0];
            bfr_pkg::CSR_SYNC_VALUE:  cfg_in.sync_value  = csr_wdata[bfr_pkg::BYTE_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dev_class   <= bfr_pkg::DEV_CLASS_RST;
         cfg_ff.unit_number <= bfr_pkg::UNIT_NUMBER_RST;
         cfg_ff.sync_value  <= bfr_pkg::SYNC_VALUE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/bfr_parser.sv =====
// frame state machine and counters, one byte per step
module bfr_parser #(
   parameter int BUFFER_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfr_pkg::cfg_type              cfg,
   input  logic                          step,
   input  logic [bfr_pkg::BYTE_W-1:0]    rx_byte,
   output logic                          rslt_vld,
   output bfr_pkg::rsp_payload_type      rslt
);

   localparam logic [2:0] PH_LISTEN = 3'd0;
   localparam logic [2:0] PH_ADDR   = 3'd1;
   localparam logic [2:0] PH_CMD    = 3'd2;
   localparam logic [2:0] PH_LEN    = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;

   localparam logic [bfr_pkg::BYTE_W-1:0] MAX_LEN = bfr_pkg::BYTE_W'(BUFFER_BYTES);

   logic [2:0]                        phase_ff, phase_in;
   logic [bfr_pkg::BYTE_W-1:0]        command_ff, command_in;
   logic [bfr_pkg::BYTE_W-1:0]        length_ff, length_in;
   logic [bfr_pkg::BYTE_W-1:0]        seen_ff, seen_in;
   logic                              bcast_ff, bcast_in;
   logic [bfr_pkg::ACCEPT_W-1:0]      accepted_ff, accepted_in;
   logic [bfr_pkg::COMPLETE_W-1:0]    completed_ff, completed_in;
   logic [bfr_pkg::OVERSIZE_W-1:0]    oversize_ff, oversize_in;

   logic                              is_sync;
   logic                              addr_ok;
   logic [bfr_pkg::UNIT_W-1:0]        addr_to;
   logic                              kind;
   logic [bfr_pkg::BYTE_W-1:0]        data;
   logic [bfr_pkg::INDEX_W-1:0]       index;
   logic                              done;

   assign is_sync = (rx_byte == cfg.sync_value);
   assign addr_to = rx_byte[bfr_pkg::UNIT_W-1:0];
   assign addr_ok = rx_byte[7] && (rx_byte[4:3] == cfg.dev_class) &&
                    ((addr_to == bfr_pkg::UNIT_BROADCAST) || (addr_to == cfg.unit_number));

   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      seen_in      = seen_ff;
      bcast_in     = bcast_ff;
      accepted_in  = accepted_ff;
      completed_in = completed_ff;
      oversize_in  = oversize_ff;
      rslt_vld     = 1'b0;
      kind         = bfr_pkg::EVENT_DATA;
      data         = '0;
      index        = '0;
      done         = 1'b0;
      case (phase_ff)
         PH_ADDR: begin
            if (addr_ok) begin
               accepted_in = accepted_ff + 1'b1;
               bcast_in    = (addr_to == bfr_pkg::UNIT_BROADCAST);
               length_in   = '0;
               seen_in     = '0;
               phase_in    = PH_CMD;
            end else begin
               phase_in = PH_LISTEN;
            end
         end
         PH_CMD: begin
            if (is_sync) begin
               phase_in = PH_LISTEN;
            end else begin
               command_in = rx_byte;
               phase_in   = PH_LEN;
            end
         end
         PH_LEN: begin
            if (is_sync) begin
               phase_in = PH_LISTEN;
            end else begin
               length_in = rx_byte;
               seen_in   = '0;
               if (rx_byte > MAX_LEN) begin
                  oversize_in = oversize_ff + 1'b1;
                  phase_in    = PH_LISTEN;
                  rslt_vld    = 1'b1;
                  kind        = bfr_pkg::EVENT_OVERSIZE;
               end else if (rx_byte == '0) begin
                  completed_in = completed_ff + 1'b1;
                  phase_in     = PH_LISTEN;
                  rslt_vld     = 1'b1;
                  done         = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            seen_in  = seen_ff + 1'b1;
            done     = (seen_in == length_ff);
            rslt_vld = 1'b1;
            data     = rx_byte;
            index    = seen_ff[bfr_pkg::INDEX_W-1:0];
            if (done) begin
               completed_in = completed_ff + 1'b1;
               phase_in     = PH_LISTEN;
            end
         end
         default: begin
            phase_in = is_sync ? PH_ADDR : PH_LISTEN;
         end
      endcase
   end

   always_comb begin
      rslt.event_kind       = kind;
      rslt.frame_command    = command_in;
      rslt.data_byte        = data;
      rslt.byte_index       = index;
      rslt.last             = done;
      rslt.broadcast        = bcast_in;
      rslt.frames_accepted  = accepted_in;
      rslt.frames_completed = completed_in;
      rslt.oversize_errors  = oversize_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LISTEN;
         command_ff   <= '0;
         length_ff    <= '0;
         seen_ff      <= '0;
         bcast_ff     <= 1'b0;
         accepted_ff  <= '0;
         completed_ff <= '0;
         oversize_ff  <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         seen_ff      <= seen_in;
         bcast_ff     <= bcast_in;
         accepted_ff  <= accepted_in;
         completed_ff <= completed_in;
         oversize_ff  <= oversize_in;
      end
   end

endmodule
